// ----- rtl/vwap_band_classifier_top_macros.svh -----
// Assertion macros used by the port-level checker of the block.
`ifndef VWAP_BAND_CLASSIFIER_TOP_MACROS_SVH
`define VWAP_BAND_CLASSIFIER_TOP_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define VBC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's usual clock and reset names.
`define VBC_ASSERT(lbl, prop, msg) \
  `VBC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/vbc_pkg.sv -----
// Shared constants, types and helper functions of the vwap band classifier.
package vbc_pkg;

  localparam int PRICE_BITS  = 16;
  localparam int VOL_BITS    = 16;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_BITS    = 24;
  localparam int PERIOD_BITS = 6;
  localparam int K_BITS      = 11;
  localparam int K_FRAC      = 8;
  localparam int STATE_BITS  = 3;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam int WINDOW_DEPTH_DEF = 64;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RST = PERIOD_BITS'(50);
  localparam logic [K_BITS-1:0]      K_RST      = K_BITS'(256);

  // Mean of squares and variance carry 2F fraction bits; sd carries F.
  localparam int M_W         = 2 * PRICE_BITS + 2 * FRAC_BITS;
  localparam int SD_W        = M_W / 2;
  localparam int SQRT_ITERS  = M_W / 2;
  localparam int KDEV_W      = K_BITS + SD_W - K_FRAC;

  localparam logic signed [STATE_BITS-1:0] BAND_ABOVE_UPPER = 3'sd2;
  localparam logic signed [STATE_BITS-1:0] BAND_ABOVE_VWAP  = 3'sd1;
  localparam logic signed [STATE_BITS-1:0] BAND_AT_VWAP     = 3'sd0;
  localparam logic signed [STATE_BITS-1:0] BAND_BELOW_VWAP  = -3'sd1;
  localparam logic signed [STATE_BITS-1:0] BAND_BELOW_LOWER = -3'sd2;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_MULT   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic div_load_a;
    logic div_step;
    logic div_load_b;
    logic cap_m;
    logic cap_var;
    logic sq_load;
    logic sq_step;
    logic cap_kdev;
    logic out_load;
  } vbc_cmd_t;

  function automatic int vbc_div_a_iters(input int depth);
    return PRICE_BITS + VOL_BITS + $clog2(depth) + FRAC_BITS;
  endfunction

  function automatic int vbc_div_b_iters(input int depth);
    return 2 * PRICE_BITS + VOL_BITS + $clog2(depth) + 2 * FRAC_BITS;
  endfunction

endpackage

// ----- rtl/vbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/vbc_dpath.sv -----
// Datapath: bar ring, window sums, shared divider, square root and band logic.
module vbc_dpath import vbc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  vbc_cmd_t                             cmd_i,
  input  logic [PRICE_BITS-1:0]                close_price_i,
  input  logic [VOL_BITS-1:0]                  volume_i,
  input  logic [PERIOD_BITS-1:0]               period_i,
  input  logic [K_BITS-1:0]                    mult_i,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]    win_len_o,
  output logic signed [STATE_BITS-1:0]         band_state_o,
  output logic [OUT_BITS-1:0]                  vwap_o,
  output logic [OUT_BITS-1:0]                  upper_band_o,
  output logic [OUT_BITS-1:0]                  lower_band_o
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int MW     = (PERIOD_BITS + 1 > LEN_W) ? PERIOD_BITS + 1 : LEN_W;
  localparam int VW     = VOL_BITS + AW;
  localparam int S1W    = PRICE_BITS + VOL_BITS + AW;
  localparam int S2W    = 2 * PRICE_BITS + VOL_BITS + AW;
  localparam int DVD_A_W = S1W + FRAC_BITS;
  localparam int DVD_W  = S2W + 2 * FRAC_BITS;
  localparam int PP_W   = 2 * PRICE_BITS;
  localparam int PV_W   = PRICE_BITS + VOL_BITS;
  localparam int PPV_W  = 2 * PRICE_BITS + VOL_BITS;
  localparam int KP_W   = K_BITS + SD_W;
  localparam int CMP_W  = KDEV_W + 1;
  localparam int RAM_W  = PRICE_BITS + VOL_BITS;

  logic [AW-1:0]         wslot_q, rd_slot_q;
  logic [LEN_W-1:0]      held_q;
  logic [PRICE_BITS-1:0] price_q;
  logic                  vld1_q, vld2_q;
  logic [RAM_W-1:0]      rdata;
  logic [PV_W-1:0]       pv_q;
  logic [PP_W-1:0]       pp_q;
  logic [VOL_BITS-1:0]   v2_q;
  logic [PPV_W-1:0]      ppv;
  logic [VW-1:0]         vsum_q;
  logic [S1W-1:0]        s1_q;
  logic [S2W-1:0]        s2_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [VW-1:0]         rem_q;
  logic [VW:0]           trial;
  logic                  qbit;
  logic [OUT_BITS-1:0]   vwap_q;
  logic [M_W-1:0]        m_q, sq_q, var_q, x_q, r_q, bit_q, rb;
  logic [SD_W-1:0]       sd;
  logic [KP_W-1:0]       kprod;
  logic [KDEV_W-1:0]     kdev_q;
  logic [CMP_W-1:0]      vw_x, kd_x, px_x, up_sum, lo_diff;
  logic [MW-1:0]         per_len, held_x;
  logic signed [STATE_BITS-1:0] state_d, state_q;
  logic [OUT_BITS-1:0]   upper_d, lower_d, upper_q, lower_q, vwap_out_q;
  logic                  vzero;

  vbc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wslot_q),
    .wdata_i ({close_price_i, volume_i}),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_slot_q),
    .rdata_o (rdata)
  );

  // Window length: newest bar plus period bars, capped by bars held.
  assign per_len   = MW'(period_i) + MW'(1);
  assign held_x    = MW'(held_q);
  assign win_len_o = (per_len < held_x) ? LEN_W'(per_len) : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      held_q  <= '0;
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
    end else begin
      vld1_q <= cmd_i.rd;
      vld2_q <= vld1_q;
      if (cmd_i.accept) begin
        wslot_q <= (wslot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wslot_q + AW'(1);
        if (held_q != LEN_W'(WINDOW_DEPTH)) begin
          held_q <= held_q + LEN_W'(1);
        end
      end
    end
  end

  // Sum pipeline: ring read, products, accumulate.
  assign ppv = PPV_W'(pp_q) * PPV_W'(v2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q   <= close_price_i;
      rd_slot_q <= wslot_q;
      vsum_q    <= '0;
      s1_q      <= '0;
      s2_q      <= '0;
    end else begin
      if (cmd_i.rd) begin
        rd_slot_q <= (rd_slot_q == '0) ? AW'(WINDOW_DEPTH - 1) : rd_slot_q - AW'(1);
      end
      if (vld2_q) begin
        vsum_q <= vsum_q + VW'(v2_q);
        s1_q   <= s1_q + S1W'(pv_q);
        s2_q   <= s2_q + S2W'(ppv);
      end
    end
    pv_q <= PV_W'(rdata[RAM_W-1 -: PRICE_BITS]) * PV_W'(rdata[VOL_BITS-1:0]);
    pp_q <= PP_W'(rdata[RAM_W-1 -: PRICE_BITS]) * PP_W'(rdata[RAM_W-1 -: PRICE_BITS]);
    v2_q <= rdata[VOL_BITS-1:0];
  end

  // Restoring divider by the volume sum, one quotient bit per cycle.
  assign vzero = (vsum_q == '0);
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, vsum_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load_a) begin
      dvd_q <= {s1_q, {(DVD_W - S1W){1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_load_b) begin
      dvd_q <= {s2_q, {(2 * FRAC_BITS){1'b0}}};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? VW'(trial - {1'b0, vsum_q}) : VW'(trial);
      dvd_q <= {dvd_q[DVD_W-2:0], qbit};
    end
    if (cmd_i.div_load_b) begin
      vwap_q <= vzero ? '0 : dvd_q[OUT_BITS-1:0];
    end
    if (cmd_i.cap_m) begin
      m_q  <= vzero ? '0 : dvd_q[M_W-1:0];
      sq_q <= M_W'(vwap_q) * M_W'(vwap_q);
    end
    if (cmd_i.cap_var) begin
      var_q <= (m_q > sq_q) ? m_q - sq_q : '0;
    end
  end

  // Bit-by-bit integer square root of the variance.
  assign rb = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      x_q   <= var_q;
      r_q   <= '0;
      bit_q <= M_W'(1) << (M_W - 2);
    end else if (cmd_i.sq_step) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign sd    = (var_q == '0) ? SD_W'(1 << FRAC_BITS) : r_q[SD_W-1:0];
  assign kprod = KP_W'(mult_i) * KP_W'(sd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_kdev) begin
      kdev_q <= KDEV_W'(kprod >> K_FRAC);
    end
  end

  // Bands and classification of the newest close.
  assign vw_x    = CMP_W'(vwap_q);
  assign kd_x    = CMP_W'(kdev_q);
  assign px_x    = CMP_W'({price_q, {FRAC_BITS{1'b0}}});
  assign up_sum  = vw_x + kd_x;
  assign lo_diff = vw_x - kd_x;

  always_comb begin
    upper_d = (up_sum > CMP_W'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : up_sum[OUT_BITS-1:0];
    lower_d = (vw_x > kd_x) ? lo_diff[OUT_BITS-1:0] : '0;
    priority if (px_x > up_sum) begin
      state_d = BAND_ABOVE_UPPER;
    end else if (px_x > vw_x) begin
      state_d = BAND_ABOVE_VWAP;
    end else if (vw_x >= kd_x && px_x < lo_diff) begin
      state_d = BAND_BELOW_LOWER;
    end else if (px_x < vw_x) begin
      state_d = BAND_BELOW_VWAP;
    end else begin
      state_d = BAND_AT_VWAP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      state_q    <= state_d;
      vwap_out_q <= vwap_q;
      upper_q    <= upper_d;
      lower_q    <= lower_d;
    end
  end

  assign band_state_o = state_q;
  assign vwap_o       = vwap_out_q;
  assign upper_band_o = upper_q;
  assign lower_band_o = lower_q;

endmodule

// ----- rtl/vbc_ctrl.sv -----
// Controller: sequences window sum, divisions, square root and result handoff.
module vbc_ctrl import vbc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0] win_len_i,
  output vbc_cmd_t                          cmd_o
);

  localparam int DIV_A_ITERS = vbc_div_a_iters(WINDOW_DEPTH);
  localparam int DIV_B_ITERS = vbc_div_b_iters(WINDOW_DEPTH);
  localparam int MAX_CNT = (WINDOW_DEPTH > DIV_B_ITERS) ? WINDOW_DEPTH : DIV_B_ITERS;
  localparam int CNT_W   = $clog2(MAX_CNT + 1);
  localparam int DRAIN_CYCLES = 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DRAIN, ST_DIVA_LD, ST_DIVA, ST_DIVB_LD, ST_DIVB,
    ST_MSQ, ST_VAR, ST_SQ_LD, ST_SQRT, ST_KDEV, ST_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.rd         = (state_q == ST_SUM);
    cmd_o.div_load_a = (state_q == ST_DIVA_LD);
    cmd_o.div_step   = (state_q == ST_DIVA) || (state_q == ST_DIVB);
    cmd_o.div_load_b = (state_q == ST_DIVB_LD);
    cmd_o.cap_m      = (state_q == ST_MSQ);
    cmd_o.cap_var    = (state_q == ST_VAR);
    cmd_o.sq_load    = (state_q == ST_SQ_LD);
    cmd_o.sq_step    = (state_q == ST_SQRT);
    cmd_o.cap_kdev   = (state_q == ST_KDEV);
    cmd_o.out_load   = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken; a new load below overrides
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (cnt_q + CNT_W'(1) == CNT_W'(win_len_i)) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (cnt_q == CNT_W'(DRAIN_CYCLES - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DIVA_LD;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DIVA_LD: begin
          state_q <= ST_DIVA;
        end
        ST_DIVA: begin
          if (cnt_q == CNT_W'(DIV_A_ITERS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DIVB_LD;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_DIVB_LD: begin
          state_q <= ST_DIVB;
        end
        ST_DIVB: begin
          if (cnt_q == CNT_W'(DIV_B_ITERS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_MSQ;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_MSQ: begin
          state_q <= ST_VAR;
        end
        ST_VAR: begin
          state_q <= ST_SQ_LD;
        end
        ST_SQ_LD: begin
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt_q == CNT_W'(SQRT_ITERS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_KDEV;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_KDEV: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/vwap_band_classifier_top.sv -----
// Top level of the rolling vwap band classifier: config registers and core.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------------
//  in       | in_valid_i / in_ready_o          | close_price_i, volume_i
//  out      | out_valid_o / out_ready_i        | band_state_o, vwap_o, upper/lower
//  config   | psel/penable/pwrite, pready = 1  | paddr, pwdata, prdata
//
// One bar at a time: the window sum reads the ring one bar per cycle, and the
// shared divider and square root each retire one bit per cycle.
// Reset clears the ring write pointer and bar count; ring contents need no clearing.
// A waiting result holds in the output register; the next bar is taken and
// computed meanwhile, and stalls only at the final handoff.
module vwap_band_classifier_top import vbc_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [PRICE_BITS-1:0]        close_price_i,
  input  logic [VOL_BITS-1:0]          volume_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [STATE_BITS-1:0] band_state_o,
  output logic [OUT_BITS-1:0]          vwap_o,
  output logic [OUT_BITS-1:0]          upper_band_o,
  output logic [OUT_BITS-1:0]          lower_band_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);

  logic [PERIOD_BITS-1:0] period_q;
  logic [K_BITS-1:0]      mult_q;
  logic                   cfg_wr;
  reg_idx_e               reg_idx;
  vbc_cmd_t               cmd;
  logic [LEN_W-1:0]       win_len;

  // Registers sit on word addresses; bit 2 selects the register.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      mult_q   <= K_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PERIOD: period_q <= pwdata[PERIOD_BITS-1:0];
        REG_MULT:   mult_q   <= pwdata[K_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = APB_DW'(period_q);
      REG_MULT:   prdata = APB_DW'(mult_q);
      default:    prdata = '0;
    endcase
  end

  // Sequencer: walks each transaction through sum, divide, root, handoff.
  vbc_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .win_len_i   (win_len),
    .cmd_o       (cmd)
  );

  // Arithmetic: ring, running sums, divider, square root, band compare.
  vbc_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .close_price_i (close_price_i),
    .volume_i      (volume_i),
    .period_i      (period_q),
    .mult_i        (mult_q),
    .win_len_o     (win_len),
    .band_state_o  (band_state_o),
    .vwap_o        (vwap_o),
    .upper_band_o  (upper_band_o),
    .lower_band_o  (lower_band_o)
  );

endmodule

// ----- rtl/vbc_chk.sv -----
// Port-level checks of the classifier, bound to the top level.
`include "vwap_band_classifier_top_macros.svh"

module vbc_chk import vbc_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [STATE_BITS-1:0] band_state_o,
  input logic [OUT_BITS-1:0]          vwap_o,
  input logic [OUT_BITS-1:0]          upper_band_o,
  input logic [OUT_BITS-1:0]          lower_band_o
);

  `VBC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(vwap_o) && $stable(band_state_o), "stalled result changed")
  `VBC_ASSERT(a_lower_le_vwap, out_valid_o |-> lower_band_o <= vwap_o, "lower band above vwap")
  `VBC_ASSERT(a_upper_ge_vwap, out_valid_o |-> upper_band_o >= vwap_o, "upper band below vwap")
  `VBC_ASSERT(a_one_bar, in_valid_i && in_ready_o |=> !in_ready_o, "second bar taken while busy")

endmodule

bind vwap_band_classifier_top vbc_chk u_vbc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .band_state_o (band_state_o),
  .vwap_o       (vwap_o),
  .upper_band_o (upper_band_o),
  .lower_band_o (lower_band_o)
);

// ----- bench/vbc_checker.sv -----
// Scoreboard for the vwap band classifier: mirrors the window and checks every result.
module vbc_checker import vbc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [PRICE_BITS-1:0]        close_price_i,
  input  logic [VOL_BITS-1:0]          volume_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [STATE_BITS-1:0] band_state_i,
  input  logic [OUT_BITS-1:0]          vwap_i,
  input  logic [OUT_BITS-1:0]          upper_band_i,
  input  logic [OUT_BITS-1:0]          lower_band_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [APB_AW-1:0]            paddr_i,
  input  logic [APB_DW-1:0]            pwdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = WINDOW_DEPTH_DEF;
  localparam logic [63:0] OUT_TOP = 64'(2**OUT_BITS - 1);

  typedef struct packed {
    logic signed [STATE_BITS-1:0] state;
    logic [OUT_BITS-1:0]          vwap;
    logic [OUT_BITS-1:0]          upper;
    logic [OUT_BITS-1:0]          lower;
  } band_result_t;

  band_result_t           band_expect_q[$];
  logic [PRICE_BITS-1:0]  price_hist[DEPTH];
  logic [VOL_BITS-1:0]    vol_hist[DEPTH];
  logic [5:0]             next_slot;
  int unsigned            bars_seen;
  logic [PERIOD_BITS-1:0] period_q;
  logic [K_BITS-1:0]      mult_q;

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict_bar(input logic [PRICE_BITS-1:0] p, input logic [VOL_BITS-1:0] v);
    logic [63:0] vsum, s1, s2, avg, spread, sd, kdev, q, r, m, px, up;
    logic [5:0] idx;
    int unsigned n;
    band_result_t res;
    price_hist[next_slot] = p;
    vol_hist[next_slot] = v;
    if (bars_seen < DEPTH) bars_seen++;
    n = period_q + 1;
    if (n > DEPTH) n = DEPTH;
    if (n > bars_seen) n = bars_seen;
    vsum = 0; s1 = 0; s2 = 0;
    for (int j = 0; j < n; j++) begin
      idx = next_slot - 6'(j);
      vsum += vol_hist[idx];
      s1 += 64'(price_hist[idx]) * vol_hist[idx];
      s2 += 64'(price_hist[idx]) * price_hist[idx] * vol_hist[idx];
    end
    next_slot = next_slot + 6'd1;
    avg = 0; spread = 0;
    if (vsum != 0) begin
      avg = (s1 << FRAC_BITS) / vsum;
      q = s2 / vsum;
      r = s2 % vsum;
      m = (q << (2 * FRAC_BITS)) + ((r << (2 * FRAC_BITS)) / vsum);
      spread = (m > avg * avg) ? m - avg * avg : 0;
    end
    sd = (spread > 0) ? root_floor(spread) : (64'd1 << FRAC_BITS);
    kdev = (64'(mult_q) * sd) >> K_FRAC;
    up = avg + kdev;
    px = 64'(p) << FRAC_BITS;
    res.vwap  = OUT_BITS'(avg);
    res.upper = (up > OUT_TOP) ? OUT_BITS'(OUT_TOP) : OUT_BITS'(up);
    res.lower = (avg > kdev) ? OUT_BITS'(avg - kdev) : '0;
    if (px > up) res.state = BAND_ABOVE_UPPER;
    else if (px > avg) res.state = BAND_ABOVE_VWAP;
    else if (avg >= kdev && px < avg - kdev) res.state = BAND_BELOW_LOWER;
    else if (px < avg) res.state = BAND_BELOW_VWAP;
    else res.state = BAND_AT_VWAP;
    band_expect_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    band_result_t exp_r;
    if (!rst_ni) begin
      band_expect_q.delete();
      next_slot = '0;
      bars_seen = 0;
      period_q = PERIOD_RST;
      mult_q = K_RST;
      fail_count_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (reg_idx_e'(paddr_i[2]) == REG_PERIOD) period_q = pwdata_i[PERIOD_BITS-1:0];
        else mult_q = pwdata_i[K_BITS-1:0];
      end
      if (in_valid_i && in_ready_i) predict_bar(close_price_i, volume_i);
      if (out_valid_i && out_ready_i) begin
        if (band_expect_q.size() == 0) begin
          $error("unexpected result: band_state %0d vwap %0d", band_state_i, vwap_i);
          fail_count_o++;
        end else begin
          exp_r = band_expect_q.pop_front();
          if (band_state_i !== exp_r.state) begin
            $error("band_state: expected %0d, got %0d", exp_r.state, band_state_i);
            fail_count_o++;
          end
          if (vwap_i !== exp_r.vwap) begin
            $error("vwap: expected %0d, got %0d", exp_r.vwap, vwap_i);
            fail_count_o++;
          end
          if (upper_band_i !== exp_r.upper) begin
            $error("upper_band: expected %0d, got %0d", exp_r.upper, upper_band_i);
            fail_count_o++;
          end
          if (lower_band_i !== exp_r.lower) begin
            $error("lower_band: expected %0d, got %0d", exp_r.lower, lower_band_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = band_expect_q.size();
  end
endmodule

// ----- bench/tb.sv -----
// Top-level testbench of the vwap band classifier: stimulus, clock, reset and verdict.
module tb;
  import vbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 300;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [PRICE_BITS-1:0]        close_price_i = '0;
  logic [VOL_BITS-1:0]          volume_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic signed [STATE_BITS-1:0] band_state_o;
  logic [OUT_BITS-1:0]          vwap_o, upper_band_o, lower_band_o;
  logic                         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0]            paddr = '0;
  logic [APB_DW-1:0]            pwdata = '0;
  logic [APB_DW-1:0]            prdata;
  logic                         pready;
  int                           fail_count, pending;
  int unsigned                  cycle_count = 0;
  bit                           quiet = 1'b0;   // no idling on either side while set

  always #5 clk_i = ~clk_i;

  vwap_band_classifier_top DUT (.*);

  vbc_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .close_price_i, .volume_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .band_state_i(band_state_o), .vwap_i(vwap_o),
    .upper_band_i(upper_band_o), .lower_band_i(lower_band_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result sink: stall a random number of cycles before taking each transaction.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = 1'b0;
      repeat (quiet ? 0 : $urandom_range(0, 10)) @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Write one register through a setup and an access phase.
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Let every outstanding bar drain so the block is idle before a register write.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk_i);
  endtask

  // Offer one bar after a random gap and hold it until the block accepts it.
  task automatic send_bar(input logic [PRICE_BITS-1:0] p, input logic [VOL_BITS-1:0] v);
    repeat (quiet ? 0 : $urandom_range(0, 10)) @(negedge clk_i);
    in_valid_i = 1'b1;
    close_price_i = p;
    volume_i = v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned level, p, v, drain;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: short window, doubled sigma.
    write_reg(REG_PERIOD, 3);
    write_reg(REG_MULT, 512);
    send_bar(0, 0);              // zero volume sum: vwap 0, sd defaults to one tick
    send_bar(65535, 0);
    send_bar(65535, 65535);      // field maxima
    send_bar(0, 65535);
    repeat (4) send_bar(1000, 10); // flat prices; the 4th: zero variance, close = vwap
    send_bar(1200, 5);
    send_bar(800, 5);
    send_bar(1000, 0);

    // Directed: window of the current bar only, no band width.
    wait_idle();
    write_reg(REG_PERIOD, 0);
    write_reg(REG_MULT, 0);
    send_bar(500, 100);
    send_bar(65535, 1);
    send_bar(0, 0);

    // Directed: widest window, largest multiplier; period change rebuilds from the ring.
    wait_idle();
    write_reg(REG_PERIOD, 63);
    write_reg(REG_MULT, 2047);
    send_bar(65535, 65535);
    send_bar(1, 65535);
    send_bar(30000, 7);
    send_bar(30000, 0);
    send_bar(12345, 4321);

    // Random phases with varying settings, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin write_reg(REG_PERIOD, 1);  write_reg(REG_MULT, 2047); end
        1: begin write_reg(REG_PERIOD, 63); write_reg(REG_MULT, 0);    end
        2: begin write_reg(REG_PERIOD, 0);  write_reg(REG_MULT, $urandom_range(0, 2047)); end
        default: begin
          write_reg(REG_PERIOD, $urandom);   // upper bits are masked off
          write_reg(REG_MULT, $urandom);
        end
      endcase
      quiet = (ph == 3);
      level = $urandom_range(0, 65535);
      for (int i = 0; i < 85; i++) begin
        // Mostly prices clustered around a level so all band states occur.
        if ($urandom_range(0, 3) == 0) p = $urandom_range(0, 65535);
        else p = (level + $urandom_range(0, 400) + 65336) & 16'hFFFF;
        case ($urandom_range(0, 9))
          0: v = 0;
          1: v = $urandom_range(0, 65535);
          2: v = 65535;
          default: v = $urandom_range(1, 300);
        endcase
        send_bar(PRICE_BITS'(p), VOL_BITS'(v));
      end
      quiet = 1'b0;
    end

    // Drain the last results, then allow the block's latency to pass.
    wait_idle();
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(negedge clk_i);
      drain++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
